FILE: sv/aemld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aemld_pkg: shared types and constants
// Payload structs, register indexes and controller states for the
// accelerometer smoothing and drive block.
// ----------------------------------------------------------------------------
package aemld_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int EXTRA_FRAC  = 32 - SAMPLE_BITS;
    localparam int NUM_LANES   = 3;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [14:0] Q15_MAX    = 15'd32767;

    localparam logic [0:0] REG_SMOOTHING = 1'b0;
    localparam logic [0:0] REG_FULLSCALE = 1'b1;

    localparam logic [1:0] AXIS_TOTAL = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] motor_speed;
        logic [14:0]        led_level;
        logic [1:0]         selected_axis;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLEND,
        ST_SQUARE,
        ST_ROOT,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    // Lane control from the sequencer
    typedef struct packed {
        logic start;   // latch sample and launch blend
        logic load;    // first sample: load directly
    } lane_ctl_t;

endpackage

FILE: sv/aemld_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aemld_lane: one axis filter lane
// Holds one axis filter value, performs the EWMA update as registered products
// then a sum and round, and registers the square of the result.
// ----------------------------------------------------------------------------
module aemld_lane
    import aemld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctl_t          ctl,
    input  logic signed [15:0] sample,
    input  logic [16:0]        weight,
    output logic signed [31:0] filt,
    output logic [63:0]        square
);

    logic signed [31:0] filt_reg, filt_next;
    logic signed [31:0] samp_reg;
    logic signed [50:0] prod_new_reg, prod_old_reg;
    logic               busy_reg;
    logic               load_reg;
    logic signed [31:0] samp_ext;
    logic signed [51:0] acc;
    logic [31:0]        abs_filt;
    logic [63:0]        square_reg;

    // Sample scaled to filter precision
    assign samp_ext = 32'(signed'(sample[SAMPLE_BITS-1:0])) <<< EXTRA_FRAC;

    // Sum of weighted terms plus half, floor divide by 2^16
    assign acc = 52'(prod_new_reg) + 52'(prod_old_reg) + 52'sd32768;
    always_comb
    begin
        filt_next = filt_reg;
        if (busy_reg)
        begin
            if (load_reg)
                filt_next = samp_reg;
            else
                filt_next = 32'(acc >>> 16);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= ctl.start;
            if (ctl.start)
                load_reg <= ctl.load;
            filt_reg <= filt_next;
        end
    end

    // Weighted products, one multiply each
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            samp_reg     <= samp_ext;
            prod_new_reg <= signed'({1'b0, weight}) * samp_ext;
            prod_old_reg <= signed'({1'b0, 17'(WEIGHT_ONE - weight)}) * filt_reg;
        end
        square_reg <= abs_filt * abs_filt;
    end

    assign abs_filt = filt_reg[31] ? 32'(-filt_reg) : filt_reg;
    assign filt     = filt_reg;
    assign square   = square_reg;

endmodule

FILE: sv/aemld_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aemld_root: iterative floor square root
// Digit-by-digit root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module aemld_root
    import aemld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            rem_reg  <= value;
            res_reg  <= '0;
            bit_reg  <= 64'h4000_0000_0000_0000;
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
            // Last trial bit: root is final on the next cycle
            done_reg <= bit_reg[0];
            if (bit_reg[0])
                run_reg <= 1'b0;
        end
        else
            done_reg <= 1'b0;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

    // Root iteration never runs without a set trial bit
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> $onehot(bit_reg))
        else $error("root trial bit lost");

endmodule

FILE: sv/aemld_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aemld_div: saturating Q0.15 ratio unit
// Restoring division of a magnitude by the full-scale value, one quotient
// bit per cycle, saturating to the largest Q0.15 code.
// ----------------------------------------------------------------------------
module aemld_div
    import aemld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] mag,
    input  logic [31:0] denom,
    output logic        done,
    output logic [14:0] quot
);

    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [14:0] q_reg;
    logic [3:0]  cnt_reg;
    logic        run_reg;
    logic        sat_reg;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            sat_reg <= 1'b0;
            rem_reg <= '0;
            den_reg <= '0;
            q_reg   <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 4'd0;
            sat_reg <= (mag >= denom);
            rem_reg <= {1'b0, mag};
            den_reg <= denom;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            // 15 quotient bits: mag < denom so quotient < 2^15
            if (shifted >= {1'b0, den_reg})
            begin
                rem_reg <= shifted - {1'b0, den_reg};
                q_reg   <= {q_reg[13:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[13:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd14)
                run_reg <= 1'b0;
        end
    end

    assign done = !run_reg && (cnt_reg == 4'd15);
    assign quot = sat_reg ? Q15_MAX : q_reg;

    // The quotient count never passes fifteen
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> cnt_reg < 4'd15)
        else $error("divider overran");

endmodule

FILE: sv/accel_ewma_motor_led_drive.sv
`timescale 1ns / 1ps
// Sequence: a sample passes blend, square and sum, the serial square root,
//   two ratio divides and the output step before its result is shown.
// Flow: a new sample waits until the last one leaves the output step; a tap
//   is taken in idle with no result; a held result stalls the output step.
// Reset: filters clear, first-sample flag sets, axis selects X, registers
//   return to weight 13107 and full scale 2560.
// ----------------------------------------------------------------------------
// accel_ewma_motor_led_drive: smoothed accelerometer to motor and LED drive
// Three filter lanes feed a shared root and divider; a sequencer merges the
// lane results into motor speed and LED level.
// ----------------------------------------------------------------------------
module accel_ewma_motor_led_drive
    import aemld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    logic [16:0] weight_reg;
    logic [14:0] fscale_reg;
    logic        first_reg;
    logic [1:0]  axis_reg;
    logic [1:0]  sel_axis_reg;
    state_t      state_reg, state_next;
    logic [1:0]  wait_reg;

    lane_ctl_t          lctl;
    logic [16:0]        wsat;
    logic signed [31:0] filt [NUM_LANES];
    logic [63:0]        sq   [NUM_LANES];
    logic signed [15:0] samp [NUM_LANES];

    logic [63:0] sum_reg;
    logic        root_start, root_done;
    logic [31:0] root_val, mag_reg;
    logic        div_start, div_done;
    logic [31:0] div_mag, denom;
    logic [14:0] quot;
    logic        second_reg;
    logic [14:0] speed_reg;
    logic        neg_reg;
    logic signed [31:0] sel_filt;

    logic        out_valid_reg;
    out_item_t   out_reg;
    logic        accept, finish;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= 17'd13107;
            fscale_reg <= 15'd2560;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SMOOTHING: weight_reg <= cfg_data;
                REG_FULLSCALE: fscale_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign wsat  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign denom = 32'((fscale_reg == '0) ? 15'd1 : fscale_reg) << EXTRA_FRAC;

    // Lanes
    assign lctl.start = accept && !in_data.cmd;
    assign lctl.load  = first_reg;
    assign samp[0] = in_data.accel_x;
    assign samp[1] = in_data.accel_y;
    assign samp[2] = in_data.accel_z;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        aemld_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (lctl),
            .sample (samp[i]),
            .weight (wsat),
            .filt   (filt[i]),
            .square (sq[i])
        );
    end

    aemld_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (sum_reg),
        .done  (root_done),
        .root  (root_val)
    );

    // Selected quantity for the first divide, magnitude for the second
    assign sel_filt = (sel_axis_reg == 2'd0) ? filt[0] :
                      (sel_axis_reg == 2'd1) ? filt[1] : filt[2];
    assign div_mag = (state_reg == ST_DIVIDE) ? mag_reg :
                     (sel_axis_reg == AXIS_TOTAL) ? root_val :
                     (sel_filt[31] ? 32'(-sel_filt) : sel_filt);

    aemld_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (div_mag),
        .denom (denom),
        .done  (div_done),
        .quot  (quot)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (lctl.start) state_next = ST_BLEND;
            ST_BLEND:  if (wait_reg == 2'd1) state_next = ST_SQUARE;
            ST_SQUARE: if (wait_reg == 2'd1) state_next = ST_ROOT;
            ST_ROOT:   if (root_done) state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_done && second_reg) state_next = ST_OUTPUT;
            ST_OUTPUT: if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        root_start = 1'b0;
        div_start  = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            ST_SQUARE: root_start = (wait_reg == 2'd1);
            ST_ROOT:   div_start  = root_done;
            ST_DIVIDE: div_start  = div_done && !second_reg;
            ST_OUTPUT: finish     = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= '0;
            first_reg     <= 1'b1;
            axis_reg      <= '0;
            sel_axis_reg  <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= (state_next != state_reg) ? 2'd0 : wait_reg + 2'd1;
            if (accept && in_data.cmd)
                axis_reg <= axis_reg + 2'd1;
            if (lctl.start)
            begin
                first_reg    <= 1'b0;
                sel_axis_reg <= axis_reg;
            end
            if (root_done)
                second_reg <= 1'b0;
            else if (div_done && state_reg == ST_DIVIDE && !second_reg)
                second_reg <= 1'b1;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers: sum of squares, magnitude, results
    always_ff @(posedge clk)
    begin
        sum_reg <= sq[0] + sq[1] + sq[2];
        if (root_done)
            mag_reg <= root_val;
        if (root_done)
            neg_reg <= (sel_axis_reg != AXIS_TOTAL) && sel_filt[31];
        if (div_done && state_reg == ST_DIVIDE && !second_reg)
            speed_reg <= quot;
        if (finish)
        begin
            out_reg.motor_speed   <= neg_reg ? -signed'({1'b0, speed_reg})
                                             : signed'({1'b0, speed_reg});
            out_reg.led_level     <= quot;
            out_reg.selected_axis <= sel_axis_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A new result never overwrites one still held by the receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !(out_valid_reg && out_stall))
        else $error("pending result overwritten");
    // Result rises only out of the output step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUTPUT)
        else $error("result without output step");
    // Root only starts from the square step
    assert property (@(posedge clk) disable iff (!rst_n)
        root_start |-> state_reg == ST_SQUARE)
        else $error("root start out of sequence");

endmodule

FILE: tb/accel_ewma_motor_led_drive_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_ewma_motor_led_drive_tb: self-checking bench for the drive block
// Sends directed and random accelerometer and tap transactions, predicts the
// smoothed motor and LED outputs in the bench, and checks every result in
// order. Both sides idle in random bursts; the receiver holds off once long.
// ----------------------------------------------------------------------------
module accel_ewma_motor_led_drive_tb;
    import aemld_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY_PAD    = 200;
    localparam int RANDOM_ITEMS   = 430;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [16:0] cfg_data;

    accel_ewma_motor_led_drive uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    logic [16:0]        weight_reg;
    logic [14:0]        fullscale_reg;
    logic signed [31:0] filt_x, filt_y, filt_z;
    logic               first_pending;
    logic [1:0]         axis_sel;

    out_item_t drive_queue[$];
    int        fail_count;
    int        idle_cycles;
    bit        quiet_mode;
    bit        hold_request;

    // Directed stimulus: known result typed where obvious
    typedef struct {
        in_item_t  item;
        bit        known;
        out_item_t result;
    } stim_row_t;

    always #5 clk = ~clk;

    function automatic logic signed [31:0] smooth_axis(logic signed [31:0] prev,
                                                      logic signed [31:0] smp,
                                                      logic [16:0] w);
        longint acc;
        longint q;
        acc = longint'(w) * longint'(smp) + longint'(65536 - w) * longint'(prev)
            + 64'sd32768;
        if (acc >= 0)
            q = acc / 65536;
        else
            q = -((-acc + 65535) / 65536);
        return q[31:0];
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [14:0] ratio_q15(longint unsigned mag,
                                              longint unsigned den);
        if (mag >= den)
            return Q15_MAX;
        return 15'((mag * 32768) / den);
    endfunction

    function automatic longint unsigned abs32(logic signed [31:0] v);
        return v < 0 ? longint'(-longint'(v)) : longint'(v);
    endfunction

    // Advance the predictor by one transaction; returns 1 if a result follows
    function automatic bit predict_drive(in_item_t it, output out_item_t r);
        logic signed [31:0] sx, sy, sz, pick;
        logic [16:0]        w;
        longint unsigned    sum, mag, den, pmag;
        logic [14:0]        spd;
        bit                 neg;
        r = '0;
        if (it.cmd) begin
            axis_sel = axis_sel + 2'd1;
            return 0;
        end
        sx = {it.accel_x, 16'h0};
        sy = {it.accel_y, 16'h0};
        sz = {it.accel_z, 16'h0};
        if (first_pending) begin
            filt_x = sx;
            filt_y = sy;
            filt_z = sz;
            first_pending = 1'b0;
        end
        else begin
            w = weight_reg > WEIGHT_ONE ? WEIGHT_ONE : weight_reg;
            filt_x = smooth_axis(filt_x, sx, w);
            filt_y = smooth_axis(filt_y, sy, w);
            filt_z = smooth_axis(filt_z, sz, w);
        end
        sum = abs32(filt_x) * abs32(filt_x) + abs32(filt_y) * abs32(filt_y)
            + abs32(filt_z) * abs32(filt_z);
        mag = isqrt64(sum);
        den = longint'(fullscale_reg == 0 ? 15'd1 : fullscale_reg) << EXTRA_FRAC;
        neg = 0;
        if (axis_sel == AXIS_TOTAL)
            pmag = mag;
        else begin
            pick = axis_sel == 2'd0 ? filt_x : axis_sel == 2'd1 ? filt_y : filt_z;
            neg = pick < 0;
            pmag = abs32(pick);
        end
        spd = ratio_q15(pmag, den);
        r.motor_speed   = neg ? -$signed({1'b0, spd}) : $signed({1'b0, spd});
        r.led_level     = ratio_q15(mag, den);
        r.selected_axis = axis_sel;
        return 1;
    endfunction

    // Stall generator for the result side
    initial begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_request = 0;
                out_stall <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (drive_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_data);
                fail_count++;
            end
            else begin
                want = drive_queue.pop_front();
                if (out_data.motor_speed !== want.motor_speed) begin
                    $display("%0t: motor_speed expected %0d actual %0d", $time,
                             want.motor_speed, out_data.motor_speed);
                    fail_count++;
                end
                if (out_data.led_level !== want.led_level) begin
                    $display("%0t: led_level expected %0d actual %0d", $time,
                             want.led_level, out_data.led_level);
                    fail_count++;
                end
                if (out_data.selected_axis !== want.selected_axis) begin
                    $display("%0t: selected_axis expected %0d actual %0d", $time,
                             want.selected_axis, out_data.selected_axis);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || hold_request)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("accel_ewma_motor_led_drive_tb NOT OK");
            $finish;
        end
    end

    // Valid stays high after acceptance so the next transaction can follow
    task automatic send_item(in_item_t it, bit known, out_item_t kres);
        out_item_t r;
        int        n;
        if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_drive(it, r)) begin
            if (known && r !== kres) begin
                $display("%0t: table row expected %h predicted %h", $time, kres, r);
                fail_count++;
            end
            drive_queue.push_back(r);
        end
    endtask

    task automatic write_reg(logic [0:0] idx, logic [16:0] val);
        in_valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_SMOOTHING)
            weight_reg = val;
        else
            fullscale_reg = val[14:0];
    endtask

    function automatic in_item_t sample_item(logic [15:0] x, logic [15:0] y,
                                             logic [15:0] z);
        in_item_t it;
        it.cmd = 1'b0;
        it.accel_x = x;
        it.accel_y = y;
        it.accel_z = z;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       span;
        it.cmd = ($urandom_range(0, 9) == 0);
        span = $urandom_range(0, 3);
        if (span == 0) begin
            it.accel_x = 16'($urandom);
            it.accel_y = 16'($urandom);
            it.accel_z = 16'($urandom);
        end
        else begin
            it.accel_x = $signed(16'($urandom_range(0, 6000))) - 16'sd3000;
            it.accel_y = $signed(16'($urandom_range(0, 6000))) - 16'sd3000;
            it.accel_z = $signed(16'($urandom_range(0, 6000))) - 16'sd3000;
        end
        return it;
    endfunction

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        in_item_t  tap;
        int        k;

        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_index = REG_SMOOTHING;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        quiet_mode = 0;
        hold_request = 0;
        weight_reg = 17'd13107;
        fullscale_reg = 15'd2560;
        filt_x = 0;
        filt_y = 0;
        filt_z = 0;
        first_pending = 1;
        axis_sel = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tap = '0;
        tap.cmd = 1'b1;
        tap.accel_x = 16'h7fff;

        // First sample after reset: 1 g on X, full scale 10 g
        row.item = sample_item(16'd256, 16'd0, 16'd0);
        row.known = 1;
        row.result = '{16'sd3276, 15'd3276, 2'd0};
        rows.push_back(row);
        row.known = 0;
        row.result = '0;
        row.item = sample_item(16'h7fff, 16'h7fff, 16'h7fff); rows.push_back(row);
        row.item = sample_item(16'h8000, 16'h8000, 16'h8000); rows.push_back(row);
        row.item = sample_item(16'h0000, 16'h0000, 16'h0000); rows.push_back(row);
        row.item = tap; rows.push_back(row);
        row.item = sample_item(16'hff00, 16'h0100, 16'h8000); rows.push_back(row);
        row.item = tap; rows.push_back(row);
        row.item = sample_item(16'h0a00, 16'hf600, 16'h0001); rows.push_back(row);
        row.item = tap; rows.push_back(row);
        row.item = sample_item(16'h1234, 16'hedcb, 16'h5555); rows.push_back(row);
        row.item = tap; rows.push_back(row);
        row.item = sample_item(16'hffff, 16'h0001, 16'haaaa); rows.push_back(row);
        for (k = 0; k < rows.size(); k++)
            send_item(rows[k].item, rows[k].known, rows[k].result);

        // Weight extremes and full scale extremes
        write_reg(REG_SMOOTHING, 17'd65536);
        write_reg(REG_FULLSCALE, 17'd1);
        send_item(sample_item(16'h0001, 16'h0000, 16'hffff), 0, '0);
        send_item(sample_item(16'h8000, 16'h7fff, 16'h0000), 0, '0);
        write_reg(REG_SMOOTHING, 17'h1ffff);
        write_reg(REG_FULLSCALE, 17'h18000);
        send_item(sample_item(16'h4000, 16'hc000, 16'h0100), 0, '0);
        write_reg(REG_SMOOTHING, 17'd0);
        write_reg(REG_FULLSCALE, 17'd32767);
        send_item(sample_item(16'h7fff, 16'h8000, 16'h1234), 0, '0);
        send_item(sample_item(16'h8000, 16'h7fff, 16'h4321), 0, '0);

        // Random phases through several settings
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 50) begin
                write_reg(REG_SMOOTHING, 17'($urandom_range(0, 131071)));
                write_reg(REG_FULLSCALE, 17'($urandom_range(0, 32767)));
            end
            if (k == 120)
                hold_request = 1;
            if (k == RANDOM_ITEMS - 60)
                quiet_mode = 1;
            send_item(random_item(), 0, '0);
        end

        // Drain
        in_valid <= 1'b0;
        k = 0;
        while (drive_queue.size() != 0 && k < 100000) begin
            @(posedge clk);
            k++;
        end
        repeat (LATENCY_PAD) @(posedge clk);
        if (fail_count == 0 && drive_queue.size() == 0)
            $display("accel_ewma_motor_led_drive_tb OK");
        else
            $display("accel_ewma_motor_led_drive_tb NOT OK");
        $finish;
    end

endmodule

FILE: accel_ewma_motor_led_drive.f
sv/aemld_pkg.sv
sv/aemld_lane.sv
sv/aemld_root.sv
sv/aemld_div.sv
sv/accel_ewma_motor_led_drive.sv
tb/accel_ewma_motor_led_drive_tb.sv
